[src/rdc_pkg.sv]
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types, constants and digit helpers for the radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

	// radix register width and its legal range
	localparam int BASE_W = 5;
	typedef logic [BASE_W-1:0] base_t;
	localparam base_t BASE_MIN   = 5'd2;
	localparam base_t BASE_MAX   = 5'd16;
	localparam base_t BASE_RESET = 5'd10;

	// one digit of the output string
	typedef logic [3:0] digit_t;
	typedef logic [6:0] char_t;

	// ascii anchors and the decimal/letter split
	localparam char_t  CHAR_ZERO  = 7'd48;
	localparam char_t  CHAR_ALPHA = 7'd65;
	localparam digit_t DEC_MAX    = 4'd9;
	localparam digit_t DEC_BASE   = 4'd10;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

	// back end status seen by the top level
	typedef struct packed {
		logic idle;
		logic converting;
		logic emitting;
	} back_status_t;

	// clamp the programmed radix into 2..16
	function automatic base_t clamp_base(input base_t b);
		base_t r;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	// digit value to ascii character
	function automatic char_t digit_to_ascii(input digit_t d);
		char_t r;
		if (d <= DEC_MAX) begin
			r = CHAR_ZERO + {3'b000, d};
		end else begin
			r = CHAR_ALPHA + {3'b000, 4'(d - DEC_BASE)};
		end
		return r;
	endfunction

endpackage

[src/rdc_queue.sv]
// ----------------------------------------------------------------------------
// rdc_queue
// two-entry request queue between the front end and the back end
// ----------------------------------------------------------------------------
module rdc_queue #(
	parameter int WIDTH = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	// occupancy flags
	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/rdc_front.sv]
// ----------------------------------------------------------------------------
// rdc_front
// request intake: radix register, clamping and queue push
// ----------------------------------------------------------------------------
module rdc_front #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [VALUE_WIDTH-1:0]              value,
	input  logic                                cfg_we,
	input  logic [rdc_pkg::BASE_W-1:0]          cfg_wdata,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [VALUE_WIDTH+rdc_pkg::BASE_W-1:0] q_data
);

	rdc_pkg::base_t base_cfg_q;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q <= rdc_pkg::BASE_RESET;
		end else if (cfg_we) begin
			base_cfg_q <= cfg_wdata;
		end
	end

	// accept a request when the queue has room, tag it with the clamped radix
	assign q_push = start & ~q_full;
	assign q_data = {rdc_pkg::clamp_base(base_cfg_q), value};

endmodule

[src/rdc_back.sv]
// ----------------------------------------------------------------------------
// rdc_back
// bit-serial radix conversion into a digit row, then msd-first emission
// ----------------------------------------------------------------------------
module rdc_back #(
	parameter int VALUE_WIDTH = 31,
	parameter int DIGIT_DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_empty,
	input  logic [VALUE_WIDTH+rdc_pkg::BASE_W-1:0] q_data,
	output logic                                   q_pop,
	output logic                                   digit_strobe,
	output logic [6:0]                             digit_char,
	output logic [3:0]                             digit_value,
	output logic                                   last_digit,
	output rdc_pkg::back_status_t                  status
);

	localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int REM_W     = $clog2(DIGIT_DEPTH + 1);

	rdc_pkg::back_state_t   state_q;
	rdc_pkg::base_t         base_q;
	logic [VALUE_WIDTH-1:0] value_sr_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   emitting_q;
	logic                   ovf_q;
	rdc_pkg::digit_t        digit_q [DIGIT_DEPTH];

	logic                   strobe_q;
	rdc_pkg::char_t         char_q;
	rdc_pkg::digit_t        value_q;
	logic                   last_q;

	logic                   bit_in;
	logic [4:0]             dbl     [DIGIT_DEPTH];
	logic [4:0]             inc     [DIGIT_DEPTH];
	rdc_pkg::digit_t        digit_next [DIGIT_DEPTH];
	logic [DIGIT_DEPTH-1:0] gen;
	logic [DIGIT_DEPTH-1:0] prop;
	logic [DIGIT_DEPTH:0]   csum;
	logic [DIGIT_DEPTH:0]   carry;
	rdc_pkg::digit_t        top_digit;
	logic                   show;
	logic                   load;

	assign bit_in    = value_sr_q[VALUE_WIDTH-1];
	assign top_digit = digit_q[DIGIT_DEPTH-1];
	assign load      = (state_q == rdc_pkg::ST_IDLE) & ~q_empty;
	assign q_pop     = load;

	// per digit: doubling always carries out, or passes the incoming carry on
	always_comb begin
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			dbl[i]  = {digit_q[i], 1'b0};
			gen[i]  = (dbl[i] >= base_q);
			prop[i] = ((dbl[i] + 5'd1) == base_q);
		end
	end

	// carry chain resolved as one wide add of generate and propagate terms
	always_comb begin
		csum = {1'b0, gen | prop} + {1'b0, gen} + {{DIGIT_DEPTH{1'b0}}, bit_in};
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			carry[i] = csum[i] ^ prop[i];
		end
		carry[DIGIT_DEPTH] = csum[DIGIT_DEPTH];
	end

	// new digit: twice old plus carry in, less the radix on carry out
	always_comb begin
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			inc[i] = dbl[i] + {4'b0000, carry[i]};
			digit_next[i] = carry[i+1] ? 4'(inc[i] - base_q) : inc[i][3:0];
		end
	end

	// emit once the first significant digit reaches the top, or after the top digit has carried out
	assign show = (state_q == rdc_pkg::ST_EMIT) &
	              (emitting_q | ovf_q | (top_digit != 4'd0));

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rdc_pkg::ST_IDLE;
			bit_cnt_q  <= '0;
			rem_q      <= '0;
			emitting_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			unique case (state_q)
				rdc_pkg::ST_IDLE: begin
					if (load) begin
						bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH);
						ovf_q     <= 1'b0;
						state_q   <= rdc_pkg::ST_CONV;
					end
				end
				rdc_pkg::ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					ovf_q     <= ovf_q | carry[DIGIT_DEPTH];
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						rem_q      <= REM_W'(DIGIT_DEPTH);
						emitting_q <= 1'b0;
						state_q    <= rdc_pkg::ST_EMIT;
					end
				end
				rdc_pkg::ST_EMIT: begin
					rem_q      <= rem_q - REM_W'(1);
					emitting_q <= emitting_q | show;
					if (rem_q == REM_W'(1)) begin
						state_q <= rdc_pkg::ST_IDLE;
					end
				end
				default: state_q <= rdc_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath: radix, input shift line and digit row
	always_ff @(posedge clk) begin
		if (load) begin
			value_sr_q <= q_data[VALUE_WIDTH-1:0];
			base_q     <= q_data[VALUE_WIDTH +: rdc_pkg::BASE_W];
			for (int i = 0; i < DIGIT_DEPTH; i++) begin
				digit_q[i] <= '0;
			end
		end else if (state_q == rdc_pkg::ST_CONV) begin
			value_sr_q <= value_sr_q << 1;
			for (int i = 0; i < DIGIT_DEPTH; i++) begin
				digit_q[i] <= digit_next[i];
			end
		end else if (state_q == rdc_pkg::ST_EMIT) begin
			digit_q[0] <= '0;
			for (int i = 1; i < DIGIT_DEPTH; i++) begin
				digit_q[i] <= digit_q[i-1];
			end
		end
	end

	// output register: strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= show;
		end
	end

	// output register: digit payload
	always_ff @(posedge clk) begin
		if (show) begin
			value_q <= top_digit;
			char_q  <= rdc_pkg::digit_to_ascii(top_digit);
			last_q  <= (rem_q == REM_W'(1));
		end
	end

	assign digit_strobe = strobe_q;
	assign digit_char   = char_q;
	assign digit_value  = value_q;
	assign last_digit   = last_q;

	// status for the top level
	assign status.idle       = (state_q == rdc_pkg::ST_IDLE);
	assign status.converting = (state_q == rdc_pkg::ST_CONV);
	assign status.emitting   = (state_q == rdc_pkg::ST_EMIT);

endmodule

[src/radix_digit_converter_unit.sv]
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// converts an unsigned integer to its digits in radix 2..16, msd first
// ----------------------------------------------------------------------------
// a request waits in the queue until the back end is idle, then shifts in one bit
//   a cycle; the DIGIT_DEPTH-digit row is then swept msd first, leading zeros
//   held back, each digit leaving through the output register
// the back end takes a new request only once the sweep of the last one is done;
// a two-entry queue takes further requests while a conversion runs
// reset clears sequencer, queue and strobe, radix back to 10; no stall on digits
module radix_digit_converter_unit #(
	parameter int VALUE_WIDTH = 31,
	parameter int DIGIT_DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [VALUE_WIDTH-1:0]     value,
	input  logic                       cfg_we,
	input  logic [rdc_pkg::BASE_W-1:0] cfg_wdata,
	output logic                       digit_strobe,
	output logic [6:0]                 digit_char,
	output logic [3:0]                 digit_value,
	output logic                       last_digit
);

	localparam int ENTRY_W = VALUE_WIDTH + rdc_pkg::BASE_W;

	logic                  q_push;
	logic                  q_pop;
	logic                  q_empty;
	logic                  q_full;
	logic [ENTRY_W-1:0]    push_data;
	logic [ENTRY_W-1:0]    pop_data;
	rdc_pkg::back_status_t back_status;

	assign busy = q_full;

	// request intake
	rdc_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	// decoupling queue
	rdc_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_data),
		.pop      (q_pop),
		.pop_data (pop_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	// conversion and emission
	rdc_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIGIT_DEPTH(DIGIT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.digit_strobe(digit_strobe),
		.digit_char  (digit_char),
		.digit_value (digit_value),
		.last_digit  (last_digit),
		.status      (back_status)
	);

	// a digit strobe always follows a cycle of the emission sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_strobe |-> $past(back_status.emitting))
	else $error("digit strobe without emission sweep");

	// no digit leaves while the shift-in loop runs
	assert property (@(posedge clk) disable iff (!arst_n)
		back_status.converting |-> !digit_strobe)
	else $error("digit strobe during conversion");

	// the final digit closes the string: no strobe right after it
	assert property (@(posedge clk) disable iff (!arst_n)
		(digit_strobe && last_digit) |=> !digit_strobe)
	else $error("digit strobe straight after final digit");

	// queue never overflows
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
	else $error("push into a full queue");

	// the back end only takes a request when idle and one is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (back_status.idle && !q_empty))
	else $error("pop outside idle or from an empty queue");

endmodule

[verif/radix_digit_converter_unit_tb.sv]
// ----------------------------------------------------------------------------
// radix_digit_converter_unit_tb
// Self-checking bench for the radix digit converter. Each strobed digit is
// checked against the oldest pending one, predicted in the current radix or,
// for typed rows, taken from the table. A directed table covers the reset
// radix, the value extremes, radix clamping and the zero input. Random
// phases follow, each under a new radix setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter_unit_tb;

	localparam int VALUE_W      = 31;
	localparam int DIGIT_DEPTH  = 32;
	localparam int IDLE_PAUSE   = 256;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 11;

	// one expected digit of the output string
	typedef struct {
		rdc_pkg::char_t  ch;
		rdc_pkg::digit_t val;
		logic            last;
	} digit_rec_t;

	// directed row: radix, value and, where obvious, the digit string
	typedef struct {
		rdc_pkg::base_t     radix;
		logic [VALUE_W-1:0] val;
		bit                 typed;
		string              digits;
	} conv_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               cfg_we;
	rdc_pkg::base_t     cfg_wdata;
	logic               digit_strobe;
	logic [6:0]         digit_char;
	logic [3:0]         digit_value;
	logic               last_digit;

	digit_rec_t     pending_digits[$];
	rdc_pkg::base_t radix_setting;
	int             error_count;

	conv_row_t directed_rows[] = '{
		'{5'd10, 31'd1,          1'b1, "1"},
		'{5'd10, 31'd0,          1'b1, ""},
		'{5'd10, 31'h7FFFFFFF,   1'b1, "2147483647"},
		'{5'd10, 31'd10,         1'b1, "10"},
		'{5'd16, 31'h7FFFFFFF,   1'b1, "7FFFFFFF"},
		'{5'd16, 31'h00ABCDEF,   1'b1, "ABCDEF"},
		'{5'd16, 31'd15,         1'b1, "F"},
		'{5'd16, 31'h55555555,   1'b0, ""},
		'{5'd2,  31'h7FFFFFFF,   1'b1, "1111111111111111111111111111111"},
		'{5'd2,  31'd1,          1'b1, "1"},
		'{5'd2,  31'h40000000,   1'b1, "1000000000000000000000000000000"},
		'{5'd2,  31'h2AAAAAAA,   1'b0, ""},
		'{5'd0,  31'd5,          1'b1, "101"},
		'{5'd1,  31'd6,          1'b1, "110"},
		'{5'd31, 31'd255,        1'b1, "FF"},
		'{5'd17, 31'd16,         1'b1, "10"},
		'{5'd3,  31'h7FFFFFFF,   1'b0, ""},
		'{5'd3,  31'd0,          1'b1, ""},
		'{5'd7,  31'd12345,      1'b0, ""},
		'{5'd9,  31'd80,         1'b1, "88"}
	};

	radix_digit_converter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.digit_strobe (digit_strobe),
		.digit_char   (digit_char),
		.digit_value  (digit_value),
		.last_digit   (last_digit)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("radix_digit_converter_unit test failed");
		$finish;
	end

	// radix actually used: out-of-range settings clamp to 2 or 16
	function automatic int unsigned effective_radix();
		if (radix_setting < 5'd2) begin
			return 2;
		end else if (radix_setting > 5'd16) begin
			return 16;
		end
		return 32'(radix_setting);
	endfunction

	// expand one value into its digits, most significant first
	task automatic predict_digits(input logic [VALUE_W-1:0] v);
		rdc_pkg::digit_t    remainders[$];
		logic [VALUE_W-1:0] quot;
		int unsigned        radix;
		digit_rec_t         rec;
		radix = effective_radix();
		quot  = v;
		while (quot != 0 && remainders.size() < DIGIT_DEPTH) begin
			remainders.push_back(rdc_pkg::digit_t'(quot % radix));
			quot = VALUE_W'(quot / radix);
		end
		for (int k = remainders.size() - 1; k >= 0; k--) begin
			rec.val  = remainders[k];
			rec.ch   = (rec.val < rdc_pkg::DEC_BASE)
				? rdc_pkg::CHAR_ZERO + 7'(rec.val)
				: rdc_pkg::CHAR_ALPHA + 7'(rec.val - rdc_pkg::DEC_BASE);
			rec.last = (k == 0);
			pending_digits.push_back(rec);
		end
	endtask

	// present one request after a gap and hold it until it is taken
	task automatic send_request(input logic [VALUE_W-1:0] v, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		value = v;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// stop requesting, wait for all pending digits, then let the block go idle
	task automatic settle_idle();
		int waited;
		waited = 0;
		start  = 1'b0;
		while (pending_digits.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_digits.size() != 0) begin
			$display("%0t: %0d expected digits never arrived", $time,
				pending_digits.size());
			error_count++;
			pending_digits.delete();
		end
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	// radix register write, only while idle
	task automatic write_radix(input rdc_pkg::base_t r);
		cfg_we    = 1'b1;
		cfg_wdata = r;
		@(negedge clk);
		cfg_we        = 1'b0;
		radix_setting = r;
	endtask

	// random gap: mostly short, now and then long
	function automatic int pick_gap(input bit no_gaps);
		if (no_gaps) begin
			return 0;
		end else if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(20, 150);
		end
		return $urandom_range(0, 3);
	endfunction

	// random value: zeros, small values, radix power boundaries, full range
	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned p;
		int unsigned     radix;
		int unsigned     kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			return '0;
		end else if (kind <= 2) begin
			return VALUE_W'($urandom_range(1, 255));
		end else if (kind <= 4) begin
			radix = effective_radix();
			p = 1;
			repeat ($urandom_range(1, 30)) begin
				if (p * radix < 64'h80000000) begin
					p = p * radix;
				end
			end
			return ($urandom_range(0, 1) != 0) ? p[VALUE_W-1:0] : VALUE_W'(p - 1);
		end
		return VALUE_W'($urandom());
	endfunction

	// digit checker
	always @(posedge clk) begin
		digit_rec_t exp_rec;
		if (arst_n && digit_strobe) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected digit char=%0d value=%0d last=%0b", $time,
					digit_char, digit_value, last_digit);
				error_count++;
			end else begin
				exp_rec = pending_digits.pop_front();
				if (digit_char !== exp_rec.ch) begin
					$display("%0t: digit_char expected %0d got %0d", $time,
						exp_rec.ch, digit_char);
					error_count++;
				end
				if (digit_value !== exp_rec.val) begin
					$display("%0t: digit_value expected %0d got %0d", $time,
						exp_rec.val, digit_value);
					error_count++;
				end
				if (last_digit !== exp_rec.last) begin
					$display("%0t: last_digit expected %0b got %0b", $time,
						exp_rec.last, last_digit);
					error_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		digit_rec_t         rec;
		conv_row_t          row;
		logic [VALUE_W-1:0] v;
		bit                 no_gaps;
		rdc_pkg::base_t     r;
		arst_n        = 1'b0;
		start         = 1'b0;
		value         = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		radix_setting = rdc_pkg::BASE_RESET;
		error_count   = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.radix != radix_setting) begin
				settle_idle();
				write_radix(row.radix);
			end
			if (row.typed) begin
				for (int j = 0; j < row.digits.len(); j++) begin
					rec.ch   = rdc_pkg::char_t'(row.digits[j]);
					rec.val  = (row.digits[j] <= "9")
						? rdc_pkg::digit_t'(row.digits[j] - "0")
						: rdc_pkg::digit_t'(row.digits[j] - "A" + 8'd10);
					rec.last = (j == row.digits.len() - 1);
					pending_digits.push_back(rec);
				end
			end else begin
				predict_digits(row.val);
			end
			send_request(row.val, $urandom_range(0, 2));
		end

		// random phases, each under its own radix setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: r = 5'd2;
				1: r = 5'd16;
				2: r = 5'd0;
				3: r = 5'd31;
				default: r = rdc_pkg::base_t'($urandom_range(0, 31));
			endcase
			settle_idle();
			write_radix(r);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				v = pick_value();
				predict_digits(v);
				send_request(v, pick_gap(no_gaps));
			end
		end

		settle_idle();
		if (error_count == 0) begin
			$display("radix_digit_converter_unit test passed");
		end else begin
			$display("radix_digit_converter_unit test failed");
		end
		$finish;
	end

endmodule
